/* hdl/tsc_pkg.sv */
`timescale 1ns / 1ps

package tsc_pkg;

  // Internal working format: unsigned magnitudes with this many fraction bits.
  localparam int WORK_BITS = 40;

  // Shared multiplier: operands are split into two halves each.
  localparam int OPND_W = 48;
  localparam int HALF_W = OPND_W / 2;
  localparam int PROD_W = 2 * OPND_W;

  // Shared divider: long division by a narrow divisor, several bits a cycle.
  localparam int DIV_W      = 64;
  localparam int DVSR_W     = 20;
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;

  // Datapath widths.
  localparam int ANGLE_W = 32;
  localparam int COS_W   = 32;
  localparam int USED_W  = 5;
  localparam int TERM_W  = 48;
  localparam int SUM_W   = 50;

  // 2 * 3.14159 = PI2_NUM / PI2_DEN.
  localparam logic [DVSR_W-1:0] PI2_NUM = 20'd628318;
  localparam logic [DVSR_W-1:0] PI2_DEN = 20'd100000;

  // 0.00001 in the working format, rounded to nearest.
  localparam logic [TERM_W-1:0] EPS_WORK = 48'd10995116;
  // 1.0 in the working format.
  localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << WORK_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_DIV_MOD,
    S_DIV_FRAC,
    S_MUL_X2,
    S_ADD,
    S_MUL_T,
    S_DIV_T,
    S_ABS,
    S_RND,
    S_OUT
  } state_t;

endpackage

/* hdl/tsc_mul.sv */
`timescale 1ns / 1ps

// Multi-cycle multiplier built on one half-width partial-product multiplier.
// The four partial products are registered and then accumulated, one a cycle.
module tsc_mul
  import tsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OPND_W-1:0] a,
  input  logic [OPND_W-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic              busy;
  logic [1:0]        cnt;
  logic              pp_vld;
  logic              pp_last;
  logic [1:0]        pp_sh;
  logic [OPND_W-1:0] a_q;
  logic [OPND_W-1:0] b_q;
  logic [OPND_W-1:0] pp;
  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;
  logic [PROD_W-1:0] pp_ext;
  logic [PROD_W-1:0] acc;

  assign a_half = cnt[1] ? a_q[OPND_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign b_half = cnt[0] ? b_q[OPND_W-1:HALF_W] : b_q[HALF_W-1:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = PROD_W'(pp);
      2'd1:    pp_ext = PROD_W'(pp) << HALF_W;
      2'd2:    pp_ext = PROD_W'(pp) << OPND_W;
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cnt     <= '0;
      pp_vld  <= 1'b0;
      pp_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
      pp_vld  <= busy;
      pp_last <= busy && (cnt == 2'd3);
      done    <= pp_vld && pp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (busy) begin
      pp    <= a_half * b_half;
      pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
    end
    if (start) begin
      acc <= '0;
    end else if (pp_vld) begin
      acc <= acc + pp_ext;
    end
  end

  assign prod = acc;

endmodule

/* hdl/tsc_div.sv */
`timescale 1ns / 1ps

// Restoring long division of a wide dividend by a narrow divisor.
// The remainder stays narrow, so several quotient bits are settled each cycle.
module tsc_div
  import tsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient,
  output logic [DVSR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_CYCLES);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  work;
  logic [DIV_W-1:0]  work_next;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] rem_next;
  logic [DVSR_W-1:0] dvsr;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    logic [DVSR_W:0] t;
    t         = '0;
    rem_next  = rem;
    work_next = work;
    for (int k = 0; k < DIV_STEP; k++) begin
      t         = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvsr}) begin
        rem_next     = DVSR_W'(t - {1'b0, dvsr});
        work_next[0] = 1'b1;
      end else begin
        rem_next = t[DVSR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
        end
      end
      done <= busy && (cnt == CNT_W'(DIV_CYCLES - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

/* hdl/taylor_series_cosine_top.sv */
`timescale 1ns / 1ps

// Taylor-series cosine of a fixed-point angle.
// The input channel (in_valid, in_ready, angle_in) takes one word: a signed
// angle in radians with ANGLE_FRACTION_BITS fraction bits. The output channel
// (out_valid, out_ready, cos_value, terms_used) returns one word per input:
// the cosine in signed fixed point with RESULT_FRACTION_BITS fraction bits,
// saturated to plus or minus one, and the number of series terms summed.
// One word is worked on at a time. The next word can be accepted in the
// cycle after the result is loaded. The shared multiplier (four partial
// products) and the shared divider (eight quotient bits a cycle) serve the
// range reduction, x squared and, for each new term, one product and one
// divide.
// A finished result sits in an output register; while the receiver stalls
// it holds there and the block still accepts and works on the next word,
// waiting at the end only if the previous result has not been taken.
// Synchronous reset clears the sequencer and the output valid flag; a word
// in flight is dropped.
module taylor_series_cosine_top
  import tsc_pkg::*;
#(
  parameter int MAX_TERMS            = 16,
  parameter int ANGLE_FRACTION_BITS  = 20,
  parameter int RESULT_FRACTION_BITS = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ANGLE_W-1:0] angle_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COS_W-1:0]  cos_value,
  output logic [USED_W-1:0]        terms_used
);

  // The term counter must hold MAX_TERMS and at least fill terms_used.
  localparam int NW_RAW = $clog2(MAX_TERMS + 1);
  localparam int NW     = (NW_RAW > USED_W) ? NW_RAW : USED_W;
  localparam int TD_W   = 2 * (NW + 1);
  localparam int A_BITS = ANGLE_FRACTION_BITS;
  localparam int R_BITS = RESULT_FRACTION_BITS;
  localparam int SHIFT  = WORK_BITS - R_BITS;
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (SHIFT - 1);
  localparam logic [SUM_W-1:0] ONE_OUT = SUM_W'(1) << R_BITS;

  state_t state;
  state_t state_next;

  // Shared arithmetic units.
  logic              mul_start;
  logic [OPND_W-1:0] mul_a;
  logic [OPND_W-1:0] mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DVSR_W-1:0] div_rem;

  // Datapath registers.
  logic [A_BITS-1:0]       plo;
  logic [TERM_W-1:0]       x2;
  logic [TERM_W-1:0]       term;
  logic signed [SUM_W-1:0] sum;
  logic                    neg;
  logic [NW-1:0]           n;
  logic                    sgn;
  logic [SUM_W-1:0]        mabs;
  logic [R_BITS:0]         rnd;

  logic [ANGLE_W-1:0] mag_in;
  logic [OPND_W-1:0]  p_lo48;
  logic [DIV_W-1:0]   frac_dividend;
  logic [NW:0]        n2;
  logic [TD_W-1:0]    tdiv_full;
  logic [SUM_W-1:0]   rounded;
  logic [SUM_W-1:0]   rsat;
  logic               stop;
  logic               out_free;

  tsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Cosine is even, so only the magnitude of the angle matters. The most
  // negative angle wraps to its exact magnitude in unsigned form.
  assign mag_in = angle_in[ANGLE_W-1] ? (ANGLE_W'(0) - $unsigned(angle_in))
                                      : $unsigned(angle_in);

  // Range reduction works on P = |angle| * 100000. The modulus 628318 << A
  // splits into a remainder of the upper bits by 628318, with the low A bits
  // carried across unchanged. The reduced angle is then that remainder,
  // scaled to the working format and divided by 100000.
  assign p_lo48        = mul_prod[OPND_W-1:0];
  assign frac_dividend = (DIV_W'(div_rem) << WORK_BITS)
                       | (DIV_W'(plo) << (WORK_BITS - A_BITS));

  // Divisor for the next term: (2n - 1) * 2n.
  assign n2        = {n, 1'b0};
  assign tdiv_full = TD_W'(n2) * TD_W'(n2 - 1'b1);

  // The series ends after the term that falls below the threshold, or at
  // the term limit.
  assign stop = (term < EPS_WORK) || (n == NW'(MAX_TERMS));

  assign rounded  = (mabs + HALF) >> SHIFT;
  assign rsat     = (rounded > ONE_OUT) ? ONE_OUT : rounded;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_MUL_P;
      S_MUL_P:    if (mul_done) state_next = S_DIV_MOD;
      S_DIV_MOD:  if (div_done) state_next = S_DIV_FRAC;
      S_DIV_FRAC: if (div_done) state_next = S_MUL_X2;
      S_MUL_X2:   if (mul_done) state_next = S_ADD;
      S_ADD:      state_next = stop ? S_ABS : S_MUL_T;
      S_MUL_T:    if (mul_done) state_next = S_DIV_T;
      S_DIV_T:    if (div_done) state_next = S_ADD;
      S_ABS:      state_next = S_RND;
      S_RND:      state_next = S_OUT;
      S_OUT:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Unit launches and operand selection. Each unit latches its operands at
  // the edge where its start is high.
  always_comb begin
    in_ready     = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        mul_start = in_valid;
        mul_a     = OPND_W'(mag_in);
        mul_b     = OPND_W'(PI2_DEN);
      end
      S_MUL_P: begin
        div_start    = mul_done;
        div_dividend = DIV_W'(p_lo48 >> A_BITS);
        div_divisor  = PI2_NUM;
      end
      S_DIV_MOD: begin
        div_start    = div_done;
        div_dividend = frac_dividend;
        div_divisor  = PI2_DEN;
      end
      S_DIV_FRAC: begin
        mul_start = div_done;
        mul_a     = div_quot[OPND_W-1:0];
        mul_b     = div_quot[OPND_W-1:0];
      end
      S_ADD: begin
        mul_start = !stop;
        mul_a     = OPND_W'(term);
        mul_b     = OPND_W'(x2);
      end
      S_MUL_T: begin
        div_start    = mul_done;
        div_dividend = DIV_W'(mul_prod[PROD_W-1:WORK_BITS]);
        div_divisor  = DVSR_W'(tdiv_full);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_P && mul_done) begin
      plo <= p_lo48[A_BITS-1:0];
    end
    if (state == S_MUL_X2 && mul_done) begin
      x2   <= mul_prod[WORK_BITS+TERM_W-1:WORK_BITS];
      term <= TERM_ONE;
      sum  <= '0;
      neg  <= 1'b0;
      n    <= NW'(1);
    end
    if (state == S_ADD) begin
      if (neg) begin
        sum <= sum - $signed(SUM_W'(term));
      end else begin
        sum <= sum + $signed(SUM_W'(term));
      end
    end
    if (state == S_DIV_T && div_done) begin
      term <= div_quot[TERM_W-1:0];
      neg  <= !neg;
      n    <= n + 1'b1;
    end
    if (state == S_ABS) begin
      sgn  <= sum[SUM_W-1];
      mabs <= sum[SUM_W-1] ? (SUM_W'(0) - $unsigned(sum)) : $unsigned(sum);
    end
    if (state == S_RND) begin
      rnd <= rsat[R_BITS:0];
    end
    if (state == S_OUT && out_free) begin
      cos_value  <= sgn ? $signed(COS_W'(0) - COS_W'(rnd)) : $signed(COS_W'(rnd));
      terms_used <= n[USED_W-1:0];
    end
  end

  // The output register is refilled in the same cycle it is drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* tb/taylor_series_cosine_top_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the fixed-point Taylor-series cosine. Each angle
// word sent into the block goes through an independent bit-exact predictor.
// The predicted cosine and term count are queued, and every word that leaves
// the block is checked against the oldest queued prediction.
module taylor_series_cosine_top_tb;
  import tsc_pkg::ANGLE_W;
  import tsc_pkg::COS_W;
  import tsc_pkg::USED_W;

  // The block is built with its default sizes, and the predictor uses the same ones.
  localparam int SERIES_LIMIT = 16;
  localparam int ANGLE_FRAC   = 20;
  localparam int RESULT_FRAC  = 30;

  // The predictor's own working format. Magnitudes carry 40 fraction bits.
  localparam int FRAC_WORK = 40;
  // 2 * 3.14159 is written as an exact ratio of two integers.
  localparam logic [63:0] TWO_PI_NUM = 64'd628318;
  localparam logic [63:0] TWO_PI_DEN = 64'd100000;
  // The closing wait allows for a series of every term and more.
  localparam int DRAIN_CYCLES = 300;

  // An angle of pi and a full turn, both with ANGLE_FRAC fraction bits.
  localparam int PI_FIX     = 3294195;
  localparam int TWO_PI_FIX = 6588391;

  typedef struct {
    logic [ANGLE_W-1:0]       angle;
    logic signed [COS_W-1:0]  cosine;
    logic [USED_W-1:0]        terms;
  } cos_prediction_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] angle_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COS_W-1:0]   cos_value;
  logic [USED_W-1:0]         terms_used;

  cos_prediction_t pending_cos_q[$];
  int              error_count = 0;
  // These flags turn random idling on or off. The last part of the run clears both.
  bit              sender_idles = 1'b1;
  bit              receiver_idles = 1'b1;

  taylor_series_cosine_top #(
    .MAX_TERMS(SERIES_LIMIT),
    .ANGLE_FRACTION_BITS(ANGLE_FRAC),
    .RESULT_FRACTION_BITS(RESULT_FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .angle_in(angle_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cos_value(cos_value),
    .terms_used(terms_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This is the working-format product. Only the bits at and above the fraction
  // point are kept, and the result is truncated to 64 bits.
  function automatic logic [63:0] work_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_WORK+63:FRAC_WORK];
  endfunction

  // This returns |angle| mod (2 * 3.14159) in the working format, truncated.
  // The remainder is found exactly in integers. Then long division yields the
  // fraction bits one at a time.
  function automatic logic [63:0] reduce_to_period(input logic [63:0] mag);
    logic [63:0] modulus;
    logic [63:0] denom;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] part;
    modulus = TWO_PI_NUM << ANGLE_FRAC;
    denom   = TWO_PI_DEN << ANGLE_FRAC;
    rem     = (mag * TWO_PI_DEN) % modulus;
    quo     = rem / denom;
    part    = rem % denom;
    for (int i = 0; i < FRAC_WORK; i++) begin
      part = part << 1;
      quo  = quo << 1;
      if (part >= denom) begin
        part = part - denom;
        quo  = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic cos_prediction_t predict_cosine(input logic [ANGLE_W-1:0] raw);
    cos_prediction_t res;
    logic [63:0]     mag;
    logic [63:0]     x;
    logic [63:0]     x_sq;
    logic [63:0]     term;
    logic [63:0]     eps;
    logic [63:0]     sum_mag;
    logic [63:0]     rounded;
    longint          sum;
    bit              term_negative;
    bit              sum_negative;
    int              used;
    mag  = raw[ANGLE_W-1] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    x    = reduce_to_period(mag);
    x_sq = work_product(x, x);
    eps  = ((64'd1 << FRAC_WORK) + 64'd50000) / 64'd100000;
    term = 64'd1 << FRAC_WORK;
    sum  = 0;
    used = 0;
    term_negative = 1'b0;
    for (int n = 1; n <= SERIES_LIMIT; n++) begin
      if (term_negative) sum = sum - $signed(term);
      else sum = sum + $signed(term);
      used = n;
      if (term < eps) break;
      term = work_product(term, x_sq) / 64'((2 * n - 1) * (2 * n));
      term_negative = !term_negative;
    end
    // Round the magnitude to the result format, with halves away from zero.
    // Clamp it at one, then put the sign back.
    sum_negative = sum < 0;
    sum_mag = sum_negative ? 64'(-sum) : 64'(sum);
    rounded = (sum_mag + (64'd1 << (FRAC_WORK - RESULT_FRAC - 1))) >> (FRAC_WORK - RESULT_FRAC);
    if (rounded > (64'd1 << RESULT_FRAC)) rounded = 64'd1 << RESULT_FRAC;
    res.angle  = raw;
    res.cosine = sum_negative ? COS_W'(64'd0 - rounded) : COS_W'(rounded);
    res.terms  = USED_W'(used);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // This sends one angle word. Sometimes a short idle burst with valid low
  // comes first. Valid is lowered only at the start of such a burst, so words
  // sent back to back keep valid high without a glitch.
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_in <= angle;
    do @(posedge clk); while (!in_ready);
    pending_cos_q.push_back(predict_cosine(angle));
  endtask

  // The receiver side mixes bursts with ready low and longer stretches
  // with ready high. Each time step gets one assignment at most.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    cos_prediction_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cos_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result cos=%h terms=%0d", cos_value, terms_used));
      end else begin
        want = pending_cos_q.pop_front();
        if (cos_value !== want.cosine)
          report_mismatch($sformatf("angle %h: cos_value %h, predicted %h",
                                    want.angle, cos_value, want.cosine));
        if (terms_used !== want.terms)
          report_mismatch($sformatf("angle %h: terms_used %0d, predicted %0d",
                                    want.angle, terms_used, want.terms));
      end
    end
  end

  // These are the extremes of the angle field. They include the most negative
  // angle, whose magnitude does not fit in 31 bits.
  task automatic test_extreme_angles();
    send_angle(32'h0000_0000);
    send_angle(32'h0000_0001);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h8000_0001);
    send_angle(32'h5555_5555);
    send_angle(32'hAAAA_AAAA);
  endtask

  // A negative angle must give the same word as its positive mirror. Each
  // angle here is sent with both signs.
  task automatic test_negative_mirror();
    int angles[4] = '{PI_FIX, PI_FIX / 2, 12345678, 1 << 20};
    foreach (angles[i]) begin
      send_angle(ANGLE_W'(angles[i]));
      send_angle(ANGLE_W'(-angles[i]));
    end
  endtask

  // Angles just below and above a full turn sit at the two ends of the
  // reduced range. The longest series of the default build comes just below
  // the turn.
  task automatic test_period_wrap();
    send_angle(ANGLE_W'(TWO_PI_FIX - 1));
    send_angle(ANGLE_W'(TWO_PI_FIX));
    send_angle(ANGLE_W'(TWO_PI_FIX + 1));
    send_angle(ANGLE_W'(-(TWO_PI_FIX + 1)));
    send_angle(ANGLE_W'(16));
  endtask

  // Random angles come from three sources. Some cover the whole 32-bit range,
  // so every bit takes both values. Some are small angles across a few turns.
  // The rest sit near a multiple of pi, where the cosine nears plus or minus one.
  task automatic test_random_angles(input int count);
    int          k;
    int          off;
    logic [31:0] a;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: a = $urandom();
        4, 5, 6, 7: a = 32'($urandom_range(0, 8 * TWO_PI_FIX)) - 32'(4 * TWO_PI_FIX);
        default: begin
          k   = $urandom_range(0, 600);
          off = int'($urandom_range(0, 64)) - 32;
          a   = 32'(k * PI_FIX + off);
          if ($urandom_range(0, 1)) a = -a;
        end
      endcase
      send_angle(a);
    end
  endtask

  // The closing stretch has no idling on either side, so the block runs at
  // its full rate.
  task automatic test_full_rate(input int count);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_angles(count);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extreme_angles();
    test_negative_mirror();
    test_period_wrap();
    test_random_angles(680);
    test_full_rate(60);
    in_valid <= 1'b0;
    while (pending_cos_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // This is the watchdog. It stops a run that hangs and reports errors.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
